>>> rtl/pfsp_pkg.sv
`default_nettype none

package pfsp_pkg;

    // Default value range of width and precision, in bits of two's complement
    localparam int VALUE_BITS_DEF = 32;

    // Format characters
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOW_H   = 8'h68;
    localparam logic [7:0] CH_LOW_L   = 8'h6C;
    localparam logic [7:0] CH_LOW_J   = 8'h6A;
    localparam logic [7:0] CH_LOW_Z   = 8'h7A;
    localparam logic [7:0] CH_UP_D    = 8'h44;
    localparam logic [7:0] CH_UP_O    = 8'h4F;
    localparam logic [7:0] CH_UP_U    = 8'h55;
    localparam logic [7:0] CH_UP_B    = 8'h42;
    localparam logic [7:0] CH_UP_C    = 8'h43;
    localparam logic [7:0] CH_UP_S    = 8'h53;
    localparam logic [7:0] CH_LOW_S   = 8'h73;
    localparam logic [7:0] CH_LOW_P   = 8'h70;
    localparam logic [7:0] CH_LOW_D   = 8'h64;
    localparam logic [7:0] CH_LOW_I   = 8'h69;
    localparam logic [7:0] CH_LOW_O   = 8'h6F;
    localparam logic [7:0] CH_LOW_U   = 8'h75;
    localparam logic [7:0] CH_LOW_X   = 8'h78;
    localparam logic [7:0] CH_UP_X    = 8'h58;
    localparam logic [7:0] CH_LOW_B   = 8'h62;
    localparam logic [7:0] CH_LOW_C   = 8'h63;

    // Flag bit positions
    localparam int FLAG_MINUS = 0;
    localparam int FLAG_PLUS  = 1;
    localparam int FLAG_HASH  = 2;
    localparam int FLAG_ZERO  = 3;
    localparam int FLAG_SPACE = 4;

    typedef enum logic [2:0] {
        LEN_NONE = 3'd0,
        LEN_HH   = 3'd1,
        LEN_H    = 3'd2,
        LEN_L    = 3'd3,
        LEN_LL   = 3'd4,
        LEN_J    = 3'd5,
        LEN_Z    = 3'd6
    } t_len;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WIDTH = 2'd1,
        PH_DOT   = 2'd2,
        PH_PREC  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_H    = 2'd1,
        PEND_L    = 2'd2
    } t_pend;

    typedef enum logic {
        ST_OK      = 1'b0,
        ST_UNKNOWN = 1'b1
    } t_status;

    // One parsed spec
    typedef struct packed {
        logic [4:0]         flag_set;
        logic               has_width;
        logic [30:0]        width_value;
        logic               has_precision;
        logic signed [31:0] precision_value;
        t_len               length_code;
        logic [7:0]         conversion;
        t_status            status;
    } t_result;

    function automatic logic is_conversion(input logic [7:0] c);
        logic r;
        case (c)
            CH_LOW_S, CH_UP_S, CH_LOW_P, CH_LOW_D, CH_UP_D, CH_LOW_I,
            CH_LOW_O, CH_UP_O, CH_LOW_U, CH_UP_U, CH_LOW_X, CH_UP_X,
            CH_LOW_B, CH_UP_B, CH_LOW_C, CH_UP_C, CH_PERCENT: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_forced_long(input logic [7:0] c);
        logic r;
        case (c)
            CH_UP_D, CH_UP_O, CH_UP_U, CH_UP_B, CH_UP_C, CH_UP_S: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/pfsp_core.sv
`default_nettype none

module pfsp_core #(
    parameter int VALUE_BITS = pfsp_pkg::VALUE_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_go,
    input  wire logic [7:0]         i_ch,
    input  wire logic signed [31:0] i_star,
    output logic                    o_done,
    output pfsp_pkg::t_result       o_res
);

    localparam int AW = VALUE_BITS - 1;
    localparam int TW = AW + 4;
    localparam logic signed [32:0] LIM_MAX = (33'sd1 <<< (VALUE_BITS - 1)) - 33'sd1;
    localparam logic signed [32:0] LIM_MIN = -LIM_MAX - 33'sd1;
    localparam logic [TW-1:0] SAT = TW'(LIM_MAX);

    // Spec state
    logic [4:0]                   r_flags, n_flags;
    logic                         r_wseen, n_wseen;
    logic [AW-1:0]                r_width, n_width;
    logic                         r_pseen, n_pseen;
    logic signed [VALUE_BITS-1:0] r_prec, n_prec;
    pfsp_pkg::t_len               r_len, n_len;
    pfsp_pkg::t_phase             r_phase, n_phase;
    pfsp_pkg::t_pend              r_pend, n_pend;
    pfsp_pkg::t_len               r_lbp, n_lbp;

    logic signed [32:0] w_star33;
    logic signed [32:0] w_star_c;
    logic signed [32:0] w_neg;
    logic [AW-1:0]      w_star_abs;
    logic [3:0]         w_digit;
    logic [AW-1:0]      w_prec_base;
    logic               w_unknown;

    // acc*10 + d, saturated at the value limit
    function automatic logic [AW-1:0] acc10(input logic [AW-1:0] acc, input logic [3:0] d);
        logic [TW-1:0] t;
        t = (TW'(acc) << 3) + (TW'(acc) << 1) + TW'(d);
        return (t > SAT) ? SAT[AW-1:0] : t[AW-1:0];
    endfunction

    function automatic pfsp_pkg::t_len raise(input pfsp_pkg::t_len cur,
                                             input pfsp_pkg::t_len code);
        return (cur < code) ? code : cur;
    endfunction

    // Star clamp and absolute value for a width star
    always_comb begin
        w_star33 = 33'(i_star);
        if (w_star33 > LIM_MAX) begin
            w_star_c = LIM_MAX;
        end else if (w_star33 < LIM_MIN) begin
            w_star_c = LIM_MIN;
        end else begin
            w_star_c = w_star33;
        end
        w_neg = -w_star_c;
        if (w_star_c < 0) begin
            w_star_abs = (w_neg > LIM_MAX) ? LIM_MAX[AW-1:0] : w_neg[AW-1:0];
        end else begin
            w_star_abs = w_star_c[AW-1:0];
        end
    end

    assign w_digit     = i_ch[3:0];
    assign w_prec_base = (r_phase == pfsp_pkg::PH_DOT) ? '0 : r_prec[AW-1:0];

    // Character decode and next state
    always_comb begin
        n_flags   = r_flags;
        n_wseen   = r_wseen;
        n_width   = r_width;
        n_pseen   = r_pseen;
        n_prec    = r_prec;
        n_len     = r_len;
        n_lbp     = r_lbp;
        n_phase   = pfsp_pkg::PH_IDLE;
        n_pend    = pfsp_pkg::PEND_NONE;
        w_unknown = 1'b0;
        o_done    = 1'b0;

        if (pfsp_pkg::is_conversion(i_ch)) begin
            if (pfsp_pkg::is_forced_long(i_ch)) begin
                n_len = pfsp_pkg::LEN_L;
            end
            o_done = 1'b1;
        end else if (i_ch >= pfsp_pkg::CH_ZERO && i_ch <= pfsp_pkg::CH_NINE
                     && r_phase != pfsp_pkg::PH_IDLE) begin
            if (r_phase == pfsp_pkg::PH_WIDTH) begin
                n_width = acc10(r_width, w_digit);
                n_phase = pfsp_pkg::PH_WIDTH;
            end else begin
                n_prec  = VALUE_BITS'(acc10(w_prec_base, w_digit));
                n_phase = pfsp_pkg::PH_PREC;
            end
        end else if (i_ch == pfsp_pkg::CH_MINUS) begin
            n_flags[pfsp_pkg::FLAG_MINUS] = 1'b1;
        end else if (i_ch == pfsp_pkg::CH_PLUS) begin
            n_flags[pfsp_pkg::FLAG_PLUS] = 1'b1;
        end else if (i_ch == pfsp_pkg::CH_HASH) begin
            n_flags[pfsp_pkg::FLAG_HASH] = 1'b1;
        end else if (i_ch == pfsp_pkg::CH_ZERO) begin
            n_flags[pfsp_pkg::FLAG_ZERO] = 1'b1;
        end else if (i_ch == pfsp_pkg::CH_SPACE) begin
            n_flags[pfsp_pkg::FLAG_SPACE] = 1'b1;
        end else if (i_ch >= pfsp_pkg::CH_ONE && i_ch <= pfsp_pkg::CH_NINE) begin
            n_wseen = 1'b1;
            n_width = AW'(w_digit);
            n_phase = pfsp_pkg::PH_WIDTH;
        end else if (i_ch == pfsp_pkg::CH_STAR) begin
            if (r_phase == pfsp_pkg::PH_DOT) begin
                n_prec = w_star_c[VALUE_BITS-1:0];
            end else begin
                n_wseen = 1'b1;
                n_width = w_star_abs;
                if (w_star_c < 0) begin
                    n_flags[pfsp_pkg::FLAG_MINUS] = 1'b1;
                end
            end
        end else if (i_ch == pfsp_pkg::CH_DOT) begin
            n_pseen = 1'b1;
            n_prec  = '0;
            n_phase = pfsp_pkg::PH_DOT;
        end else if (i_ch == pfsp_pkg::CH_LOW_H) begin
            if (r_pend == pfsp_pkg::PEND_H) begin
                n_len = raise(r_lbp, pfsp_pkg::LEN_HH);
            end else begin
                n_lbp  = r_len;
                n_len  = raise(r_len, pfsp_pkg::LEN_H);
                n_pend = pfsp_pkg::PEND_H;
            end
        end else if (i_ch == pfsp_pkg::CH_LOW_L) begin
            if (r_pend == pfsp_pkg::PEND_L) begin
                n_len = raise(r_lbp, pfsp_pkg::LEN_LL);
            end else begin
                n_lbp  = r_len;
                n_len  = raise(r_len, pfsp_pkg::LEN_L);
                n_pend = pfsp_pkg::PEND_L;
            end
        end else if (i_ch == pfsp_pkg::CH_LOW_J) begin
            n_len = raise(r_len, pfsp_pkg::LEN_J);
        end else if (i_ch == pfsp_pkg::CH_LOW_Z) begin
            n_len = raise(r_len, pfsp_pkg::LEN_Z);
        end else begin
            w_unknown = 1'b1;
            o_done    = 1'b1;
        end
    end

    // Result as it stands after this character
    always_comb begin
        o_res.flag_set        = n_flags;
        o_res.has_width       = n_wseen;
        o_res.width_value     = 31'(n_width);
        o_res.has_precision   = n_pseen;
        o_res.precision_value = 32'(n_prec);
        o_res.length_code     = n_len;
        o_res.conversion      = i_ch;
        o_res.status          = w_unknown ? pfsp_pkg::ST_UNKNOWN : pfsp_pkg::ST_OK;
    end

    // State update; a finished spec clears everything
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_go && o_done)) begin
            r_flags <= '0;
            r_wseen <= 1'b0;
            r_width <= '0;
            r_pseen <= 1'b0;
            r_prec  <= '0;
            r_len   <= pfsp_pkg::LEN_NONE;
            r_phase <= pfsp_pkg::PH_IDLE;
            r_pend  <= pfsp_pkg::PEND_NONE;
            r_lbp   <= pfsp_pkg::LEN_NONE;
        end else if (i_go) begin
            r_flags <= n_flags;
            r_wseen <= n_wseen;
            r_width <= n_width;
            r_pseen <= n_pseen;
            r_prec  <= n_prec;
            r_len   <= n_len;
            r_phase <= n_phase;
            r_pend  <= n_pend;
            r_lbp   <= n_lbp;
        end
    end

    a_clear_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go && o_done |=> r_phase == pfsp_pkg::PH_IDLE && r_pend == pfsp_pkg::PEND_NONE
                           && r_flags == '0 && !r_wseen && !r_pseen
                           && r_len == pfsp_pkg::LEN_NONE)
        else $error("spec state not cleared after a result");

    a_prec_digits_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == pfsp_pkg::PH_PREC || r_phase == pfsp_pkg::PH_DOT) |-> r_pseen)
        else $error("precision phase without a dot");

    a_pend_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend != pfsp_pkg::PEND_L || r_len >= pfsp_pkg::LEN_L)
        && (r_pend != pfsp_pkg::PEND_H || r_len >= pfsp_pkg::LEN_H))
        else $error("pending length letter without its length code");

    a_width_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == pfsp_pkg::PH_WIDTH |-> r_wseen)
        else $error("width digits without width seen");

endmodule

`default_nettype wire

>>> rtl/pfsp_out_reg.sv
`default_nettype none

module pfsp_out_reg (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire pfsp_pkg::t_result  i_res,
    input  wire logic               i_stall,
    output logic                    o_ready,
    output logic                    o_valid,
    output pfsp_pkg::t_result       o_res
);

    logic              r_valid;
    pfsp_pkg::t_result r_res;

    // Free, or emptied this cycle
    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready && i_load |=> r_valid && r_res == $past(i_res))
        else $error("loaded item not presented");

    a_no_load_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_stall |=> r_valid && $stable(r_res))
        else $error("held item overwritten");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_stall && !i_load |=> !r_valid)
        else $error("item repeated after it was taken");

endmodule

`default_nettype wire

>>> rtl/printf_format_spec_parser_top.sv
// printf format specifier parser.
// Input channel: i_valid / o_stall with i_ch (a character after the percent
// sign) and i_star_value (the next star argument, used when i_ch is '*').
// An item is taken at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with the parsed spec fields. One result
// leaves for each conversion character or unrecognized character (status 1);
// other characters only update the spec being collected.
// Path: a closing item that is taken is held in the input register, then
// decoded out of it into the result register that drives o_valid.
// Throughput: one item per cycle while o_stall is low, set by the single decode and
// multiply-by-ten accumulate stage.
// When i_stall holds a result, characters that do not end a spec still pass;
// a closing character waits in the input register and o_stall rises.
// Reset (i_rst_n low, synchronous) empties both registers and clears the
// spec state to no flags, no width, no precision and no length.
// VALUE_BITS sets the saturation limit 2^(VALUE_BITS-1)-1 of width and
// precision and the width of the accumulators.
`default_nettype none

module printf_format_spec_parser_top #(
    parameter int VALUE_BITS = pfsp_pkg::VALUE_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [7:0]         i_ch,
    input  wire logic signed [31:0] i_star_value,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [4:0]              o_flag_set,
    output logic                    o_has_width,
    output logic [30:0]             o_width_value,
    output logic                    o_has_precision,
    output logic signed [31:0]      o_precision_value,
    output logic [2:0]              o_length_code,
    output logic [7:0]              o_conversion,
    output logic                    o_status
);

    logic               r_in_valid;
    logic [7:0]         r_ch;
    logic signed [31:0] r_star;

    logic               w_done;
    logic               w_go;
    logic               w_out_ready;
    pfsp_pkg::t_result  w_res;
    pfsp_pkg::t_result  w_out;

    // Advance unless a result must wait for the output register
    assign w_go    = r_in_valid && (w_out_ready || !w_done);
    assign o_stall = r_in_valid && !w_go;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_ch   <= i_ch;
            r_star <= i_star_value;
        end
    end

    pfsp_core #(
        .VALUE_BITS(VALUE_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_ch    (r_ch),
        .i_star  (r_star),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    pfsp_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_go && w_done),
        .i_res   (w_res),
        .i_stall (i_stall),
        .o_ready (w_out_ready),
        .o_valid (o_valid),
        .o_res   (w_out)
    );

    assign o_flag_set        = w_out.flag_set;
    assign o_has_width       = w_out.has_width;
    assign o_width_value     = w_out.width_value;
    assign o_has_precision   = w_out.has_precision;
    assign o_precision_value = w_out.precision_value;
    assign o_length_code     = w_out.length_code;
    assign o_conversion      = w_out.conversion;
    assign o_status          = w_out.status;

endmodule

`default_nettype wire

>>> dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     VBITS       = pfsp_pkg::VALUE_BITS_DEF;
    localparam longint VMAX        = (longint'(1) << (VBITS - 1)) - 1;
    localparam longint VMIN        = -VMAX - 1;
    localparam int     PHASE_ITEMS = 160;
    localparam int     LONG_HOLD   = 300;
    localparam int     LIMIT       = 200000;
    localparam int     TAIL_CYCLES = 10;
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_TOP  = 8'hFF;

    typedef struct {
        logic [7:0]         ch;
        logic signed [31:0] star;
    } t_char_item;

    // DUT signals
    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_valid      = 1'b0;
    logic               o_stall;
    logic [7:0]         i_ch         = '0;
    logic signed [31:0] i_star_value = '0;
    logic               o_valid;
    logic               i_stall      = 1'b0;
    logic [4:0]         o_flag_set;
    logic               o_has_width;
    logic [30:0]        o_width_value;
    logic               o_has_precision;
    logic signed [31:0] o_precision_value;
    logic [2:0]         o_length_code;
    logic [7:0]         o_conversion;
    logic               o_status;

    // Stimulus and checking state
    t_char_item        char_q[$];
    pfsp_pkg::t_result parsed_q[$];
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    logic              recv_hold     = 1'b0;
    int                n_chars       = 0;
    int                n_specs       = 0;
    int                n_unknown     = 0;
    int                n_fail        = 0;
    int                cycles        = 0;
    event              long_hold_ev;

    // Spec being collected by the predictor
    logic [4:0]       spec_flags;
    logic             spec_wseen;
    longint           spec_wacc;
    logic             spec_pseen;
    longint           spec_pacc;
    pfsp_pkg::t_len   spec_len;
    pfsp_pkg::t_len   spec_len_pre;
    pfsp_pkg::t_phase spec_phase;
    pfsp_pkg::t_pend  spec_pend;

    printf_format_spec_parser_top uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_ch              (i_ch),
        .i_star_value      (i_star_value),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_flag_set        (o_flag_set),
        .o_has_width       (o_has_width),
        .o_width_value     (o_width_value),
        .o_has_precision   (o_has_precision),
        .o_precision_value (o_precision_value),
        .o_length_code     (o_length_code),
        .o_conversion      (o_conversion),
        .o_status          (o_status)
    );

    always #6 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    task automatic clear_spec();
        spec_flags   = '0;
        spec_wseen   = 1'b0;
        spec_wacc    = 0;
        spec_pseen   = 1'b0;
        spec_pacc    = 0;
        spec_len     = pfsp_pkg::LEN_NONE;
        spec_len_pre = pfsp_pkg::LEN_NONE;
        spec_phase   = pfsp_pkg::PH_IDLE;
        spec_pend    = pfsp_pkg::PEND_NONE;
    endtask

    // Multiply-by-ten accumulate with saturation at VMAX
    function automatic longint add_digit(longint acc, longint d);
        if (acc > (VMAX - d) / 10)
            return VMAX;
        return acc * 10 + d;
    endfunction

    function automatic logic ends_spec(logic [7:0] c);
        case (c)
            pfsp_pkg::CH_LOW_S, pfsp_pkg::CH_UP_S, pfsp_pkg::CH_LOW_P,
            pfsp_pkg::CH_LOW_D, pfsp_pkg::CH_UP_D, pfsp_pkg::CH_LOW_I,
            pfsp_pkg::CH_LOW_O, pfsp_pkg::CH_UP_O, pfsp_pkg::CH_LOW_U,
            pfsp_pkg::CH_UP_U, pfsp_pkg::CH_LOW_X, pfsp_pkg::CH_UP_X,
            pfsp_pkg::CH_LOW_B, pfsp_pkg::CH_UP_B, pfsp_pkg::CH_LOW_C,
            pfsp_pkg::CH_UP_C, pfsp_pkg::CH_PERCENT: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    task automatic raise_len(pfsp_pkg::t_len code);
        if (spec_len < code)
            spec_len = code;
    endtask

    // Apply one accepted character; push the finished spec if it closes one
    task automatic parse_char(logic [7:0] c, logic signed [31:0] sv);
        longint            star;
        longint            d;
        pfsp_pkg::t_phase  ph;
        pfsp_pkg::t_pend   pd;
        logic              fin;
        logic              bad;
        pfsp_pkg::t_result r;
        star = longint'(sv);
        if (star > VMAX) star = VMAX;
        if (star < VMIN) star = VMIN;
        ph = spec_phase;
        pd = spec_pend;
        fin = 1'b0;
        bad = 1'b0;
        d = longint'(c) - longint'(pfsp_pkg::CH_ZERO);
        spec_phase = pfsp_pkg::PH_IDLE;
        spec_pend  = pfsp_pkg::PEND_NONE;

        if (ends_spec(c)) begin
            case (c)
                pfsp_pkg::CH_UP_D, pfsp_pkg::CH_UP_O, pfsp_pkg::CH_UP_U,
                pfsp_pkg::CH_UP_B, pfsp_pkg::CH_UP_C, pfsp_pkg::CH_UP_S:
                    spec_len = pfsp_pkg::LEN_L;
                default: ;
            endcase
            fin = 1'b1;
        end else if (c >= pfsp_pkg::CH_ZERO && c <= pfsp_pkg::CH_NINE
                     && ph != pfsp_pkg::PH_IDLE) begin
            // digit inside a width or precision run
            if (ph == pfsp_pkg::PH_WIDTH) begin
                spec_wacc  = add_digit(spec_wacc, d);
                spec_phase = pfsp_pkg::PH_WIDTH;
            end else begin
                spec_pacc  = add_digit((ph == pfsp_pkg::PH_DOT) ? 0 : spec_pacc, d);
                spec_phase = pfsp_pkg::PH_PREC;
            end
        end else begin
            case (c)
                pfsp_pkg::CH_MINUS: spec_flags[pfsp_pkg::FLAG_MINUS] = 1'b1;
                pfsp_pkg::CH_PLUS:  spec_flags[pfsp_pkg::FLAG_PLUS]  = 1'b1;
                pfsp_pkg::CH_HASH:  spec_flags[pfsp_pkg::FLAG_HASH]  = 1'b1;
                pfsp_pkg::CH_ZERO:  spec_flags[pfsp_pkg::FLAG_ZERO]  = 1'b1;
                pfsp_pkg::CH_SPACE: spec_flags[pfsp_pkg::FLAG_SPACE] = 1'b1;
                pfsp_pkg::CH_STAR: begin
                    if (ph == pfsp_pkg::PH_DOT) begin
                        spec_pacc = star;
                    end else begin
                        spec_wseen = 1'b1;
                        if (star < 0) begin
                            // negative width: left-justify, take magnitude
                            spec_flags[pfsp_pkg::FLAG_MINUS] = 1'b1;
                            spec_wacc = (star < -VMAX) ? VMAX : -star;
                        end else begin
                            spec_wacc = star;
                        end
                    end
                end
                pfsp_pkg::CH_DOT: begin
                    spec_pseen = 1'b1;
                    spec_pacc  = 0;
                    spec_phase = pfsp_pkg::PH_DOT;
                end
                pfsp_pkg::CH_LOW_H: begin
                    if (pd == pfsp_pkg::PEND_H) begin
                        spec_len = spec_len_pre;
                        raise_len(pfsp_pkg::LEN_HH);
                    end else begin
                        spec_len_pre = spec_len;
                        raise_len(pfsp_pkg::LEN_H);
                        spec_pend = pfsp_pkg::PEND_H;
                    end
                end
                pfsp_pkg::CH_LOW_L: begin
                    if (pd == pfsp_pkg::PEND_L) begin
                        spec_len = spec_len_pre;
                        raise_len(pfsp_pkg::LEN_LL);
                    end else begin
                        spec_len_pre = spec_len;
                        raise_len(pfsp_pkg::LEN_L);
                        spec_pend = pfsp_pkg::PEND_L;
                    end
                end
                pfsp_pkg::CH_LOW_J: raise_len(pfsp_pkg::LEN_J);
                pfsp_pkg::CH_LOW_Z: raise_len(pfsp_pkg::LEN_Z);
                default: begin
                    if (c >= pfsp_pkg::CH_ONE && c <= pfsp_pkg::CH_NINE) begin
                        // a new width run replaces any earlier width
                        spec_wseen = 1'b1;
                        spec_wacc  = d;
                        spec_phase = pfsp_pkg::PH_WIDTH;
                    end else begin
                        bad = 1'b1;
                        fin = 1'b1;
                    end
                end
            endcase
        end

        if (fin) begin
            r.flag_set        = spec_flags;
            r.has_width       = spec_wseen;
            r.width_value     = spec_wacc[30:0];
            r.has_precision   = spec_pseen;
            r.precision_value = spec_pacc[31:0];
            r.length_code     = spec_len;
            r.conversion      = c;
            r.status          = bad ? pfsp_pkg::ST_UNKNOWN : pfsp_pkg::ST_OK;
            parsed_q.push_back(r);
            clear_spec();
        end
    endtask

    // ---------------------------------------------------------------
    // Stimulus generation
    // ---------------------------------------------------------------
    task automatic add_char(logic [7:0] c, logic signed [31:0] sv);
        t_char_item it;
        it.ch   = c;
        it.star = sv;
        char_q.push_back(it);
    endtask

    function automatic logic signed [31:0] rand_star();
        case ($urandom_range(7))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sd0;
            3: return -32'sd1;
            4: return $signed(32'($urandom_range(200))) - 32'sd100;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_conversion();
        case ($urandom_range(16))
            0:  return pfsp_pkg::CH_LOW_S;
            1:  return pfsp_pkg::CH_UP_S;
            2:  return pfsp_pkg::CH_LOW_P;
            3:  return pfsp_pkg::CH_LOW_D;
            4:  return pfsp_pkg::CH_UP_D;
            5:  return pfsp_pkg::CH_LOW_I;
            6:  return pfsp_pkg::CH_LOW_O;
            7:  return pfsp_pkg::CH_UP_O;
            8:  return pfsp_pkg::CH_LOW_U;
            9:  return pfsp_pkg::CH_UP_U;
            10: return pfsp_pkg::CH_LOW_X;
            11: return pfsp_pkg::CH_UP_X;
            12: return pfsp_pkg::CH_LOW_B;
            13: return pfsp_pkg::CH_UP_B;
            14: return pfsp_pkg::CH_LOW_C;
            15: return pfsp_pkg::CH_UP_C;
            default: return pfsp_pkg::CH_PERCENT;
        endcase
    endfunction

    function automatic logic [7:0] pick_flag();
        case ($urandom_range(4))
            0: return pfsp_pkg::CH_MINUS;
            1: return pfsp_pkg::CH_PLUS;
            2: return pfsp_pkg::CH_HASH;
            3: return pfsp_pkg::CH_ZERO;
            default: return pfsp_pkg::CH_SPACE;
        endcase
    endfunction

    // any character that does not close a spec
    function automatic logic [7:0] pick_spec_char();
        case ($urandom_range(8))
            0: return pick_flag();
            1: return pfsp_pkg::CH_STAR;
            2: return pfsp_pkg::CH_DOT;
            3: return pfsp_pkg::CH_LOW_H;
            4: return pfsp_pkg::CH_LOW_L;
            5: return pfsp_pkg::CH_LOW_J;
            6: return pfsp_pkg::CH_LOW_Z;
            default: return 8'(pfsp_pkg::CH_ZERO + $urandom_range(9));
        endcase
    endfunction

    task automatic add_digits(int n);
        repeat (n) add_char(8'(pfsp_pkg::CH_ZERO + $urandom_range(9)), $urandom);
    endtask

    // One spec: mostly well-formed with random content, some scrambled or noisy
    task automatic gen_spec();
        int mode;
        mode = $urandom_range(9);
        if (mode == 0) begin
            repeat ($urandom_range(1, 4)) add_char(8'($urandom), rand_star());
        end else if (mode == 1) begin
            repeat ($urandom_range(1, 8)) add_char(pick_spec_char(), rand_star());
        end else begin
            repeat ($urandom_range(0, 3)) add_char(pick_flag(), $urandom);
            // width
            case ($urandom_range(3))
                1: begin
                    add_char(8'(pfsp_pkg::CH_ONE + $urandom_range(8)), $urandom);
                    add_digits(($urandom_range(7) == 0) ? $urandom_range(9, 12)
                                                       : $urandom_range(0, 3));
                end
                2: add_char(pfsp_pkg::CH_STAR, rand_star());
                3: begin
                    add_char(pfsp_pkg::CH_STAR, rand_star());
                    add_char(8'(pfsp_pkg::CH_ONE + $urandom_range(8)), $urandom);
                end
                default: ;
            endcase
            // precision
            if ($urandom_range(1)) begin
                add_char(pfsp_pkg::CH_DOT, $urandom);
                case ($urandom_range(3))
                    1: add_digits(($urandom_range(7) == 0) ? $urandom_range(10, 12)
                                                          : $urandom_range(1, 3));
                    2: add_char(pfsp_pkg::CH_STAR, rand_star());
                    3: begin
                        add_digits($urandom_range(1, 2));
                        add_char(pfsp_pkg::CH_STAR, rand_star());
                    end
                    default: ;
                endcase
            end
            // length modifier
            case ($urandom_range(11))
                4: add_char(pfsp_pkg::CH_LOW_H, $urandom);
                5: repeat (2) add_char(pfsp_pkg::CH_LOW_H, $urandom);
                6: add_char(pfsp_pkg::CH_LOW_L, $urandom);
                7: repeat (2) add_char(pfsp_pkg::CH_LOW_L, $urandom);
                8: add_char(pfsp_pkg::CH_LOW_J, $urandom);
                9: add_char(pfsp_pkg::CH_LOW_Z, $urandom);
                10: repeat (3) add_char(($urandom_range(1)) ? pfsp_pkg::CH_LOW_L
                                                            : pfsp_pkg::CH_LOW_H, $urandom);
                11: begin
                    add_char(pfsp_pkg::CH_LOW_Z, $urandom);
                    add_char(pfsp_pkg::CH_LOW_H, $urandom);
                end
                default: ;
            endcase
        end
        add_char(pick_conversion(), rand_star());
    endtask

    task automatic gen_phase();
        while (char_q.size() < PHASE_ITEMS) gen_spec();
    endtask

    task automatic drain();
        while (char_q.size() != 0 || i_valid || parsed_q.size() != 0) @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Input driver: offers queued items, predicts each one taken
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : drv
        t_char_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                parse_char(i_ch, i_star_value);
                n_chars++;
            end
            if (!i_valid || !o_stall) begin
                if (char_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = char_q.pop_front();
                    i_valid      <= 1'b1;
                    i_ch         <= nxt.ch;
                    i_star_value <= nxt.star;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Output monitor and receiver stall
    // ---------------------------------------------------------------
    task automatic check_field(string what, longint want, longint got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            n_fail++;
        end
    endtask

    always @(posedge i_clk) begin : mon
        pfsp_pkg::t_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (parsed_q.size() == 0) begin
                    $display("%0t ns: unexpected result, conversion 0x%02h status %0d",
                             $time, o_conversion, o_status);
                    n_fail++;
                end else begin
                    want = parsed_q.pop_front();
                    n_specs++;
                    if (want.status == pfsp_pkg::ST_UNKNOWN) n_unknown++;
                    check_field("flag_set", want.flag_set, o_flag_set);
                    check_field("has_width", want.has_width, o_has_width);
                    check_field("width_value", want.width_value, o_width_value);
                    check_field("has_precision", want.has_precision, o_has_precision);
                    check_field("precision_value", want.precision_value,
                                o_precision_value);
                    check_field("length_code", want.length_code, o_length_code);
                    check_field("conversion", want.conversion, o_conversion);
                    check_field("status", want.status, o_status);
                end
            end
            i_stall <= recv_hold || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Long output hold-off, so the parser backs up and stalls its input
    always begin
        @(long_hold_ev);
        recv_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        recv_hold <= 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("Timeout after %0d cycles, %0d specs outstanding", cycles,
                     parsed_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        clear_spec();

        // all flags, most negative width star, negative precision star, hh
        add_char(pfsp_pkg::CH_MINUS, 32'sd0);
        add_char(pfsp_pkg::CH_PLUS, 32'sd0);
        add_char(pfsp_pkg::CH_HASH, 32'sd0);
        add_char(pfsp_pkg::CH_SPACE, 32'sd0);
        add_char(pfsp_pkg::CH_ZERO, 32'sd0);
        add_char(pfsp_pkg::CH_STAR, 32'sh8000_0000);
        add_char(pfsp_pkg::CH_DOT, 32'sd0);
        add_char(pfsp_pkg::CH_STAR, -32'sd5);
        add_char(pfsp_pkg::CH_LOW_H, 32'sd0);
        add_char(pfsp_pkg::CH_LOW_H, 32'sd0);
        add_char(pfsp_pkg::CH_LOW_D, 32'sd0);
        // repeated dot, zero as a precision digit, width star after
        // precision digits, triple l, forced long
        add_char(pfsp_pkg::CH_ONE, 32'sd0);
        add_char(pfsp_pkg::CH_NINE, 32'sd0);
        add_char(pfsp_pkg::CH_DOT, 32'sd0);
        add_char(pfsp_pkg::CH_DOT, 32'sd0);
        add_char(pfsp_pkg::CH_ZERO, 32'sd0);
        add_char(pfsp_pkg::CH_NINE, 32'sd0);
        add_char(pfsp_pkg::CH_STAR, 32'sh7FFF_FFFF);
        add_char(pfsp_pkg::CH_LOW_L, 32'sd0);
        add_char(pfsp_pkg::CH_LOW_L, 32'sd0);
        add_char(pfsp_pkg::CH_LOW_L, 32'sd0);
        add_char(pfsp_pkg::CH_UP_D, 32'sd0);
        // dot without digits, z then j
        add_char(pfsp_pkg::CH_DOT, 32'sd0);
        add_char(pfsp_pkg::CH_LOW_Z, 32'sd0);
        add_char(pfsp_pkg::CH_LOW_J, 32'sd0);
        add_char(pfsp_pkg::CH_PERCENT, 32'sd0);
        // unknown characters, the zero byte among them
        add_char(CH_NUL, -32'sd1);
        add_char(CH_TOP, -32'sd1);

        // sender mostly busy, receiver mostly stalling
        send_idle_pct = 11;
        recv_idle_pct = 82;
        gen_phase();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        drain();
        // the other way round
        send_idle_pct = 82;
        recv_idle_pct = 11;
        gen_phase();
        drain();

        // no idling, plus one long output hold-off
        send_idle_pct = 0;
        recv_idle_pct = 0;
        gen_phase();
        -> long_hold_ev;
        drain();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (parsed_q.size() != 0) begin
            $display("%0d expected specs never arrived", parsed_q.size());
            n_fail++;
        end

        $display("Sent %0d characters and checked %0d parsed specs, %0d of them unknown stops",
                 n_chars, n_specs, n_unknown);
        $display("Stall mixes: sender-idle, receiver-idle, free-running with a %0d-cycle hold",
                 LONG_HOLD);
        if (n_fail == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/pfsp_pkg.sv
rtl/pfsp_core.sv
rtl/pfsp_out_reg.sv
rtl/printf_format_spec_parser_top.sv
dv/tb_top.sv
